// ===== sv/fwm_pkg.sv =====
// Shared types and constants for the fuzzy word match block.
`default_nettype none
package fwm_pkg;

  // Word storage sizing
  localparam int WORD_STORE = 24;
  localparam int WORD_MAX   = WORD_STORE - 1;
  localparam int IDX_W      = $clog2(WORD_MAX);
  localparam int LEN_W      = $clog2(WORD_STORE + 1);
  localparam int CNT_W      = $clog2(2 * WORD_STORE);
  localparam int CHAR_W     = 8;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int DIST_W     = 5;
  localparam int CMP_W      = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int DIST_SAT   = (1 << DIST_W) - 1;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_S    = 8'h73;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_LIMIT = 8'd0,
    CFG_LONG_LIMIT  = 8'd1,
    CFG_NEAR_TOL    = 8'd2,
    CFG_FAR_TOL     = 8'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = 5'd4;
  localparam logic [CFG_W-1:0] LONG_LIMIT_RST  = 5'd8;
  localparam logic [CFG_W-1:0] NEAR_TOL_RST    = 5'd1;
  localparam logic [CFG_W-1:0] FAR_TOL_RST     = 5'd2;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } fwm_state_t;

  // Wavefront data passed from one cell to the next
  typedef struct packed {
    logic              vld;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  left;
    logic [LEN_W-1:0]  diag;
  } wave_t;

endpackage
`default_nettype wire

// ===== sv/fwm_cell.sv =====
// One column cell of the systolic edit-distance array.
`default_nettype none
module fwm_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       init,
  input  wire logic [fwm_pkg::LEN_W-1:0]  init_val,
  input  wire logic [fwm_pkg::CHAR_W-1:0] ref_char,
  input  wire fwm_pkg::wave_t             wave_in,
  output fwm_pkg::wave_t                  wave_out
);

  logic                       vld_r;
  logic [fwm_pkg::CHAR_W-1:0] ch_r;
  logic [fwm_pkg::LEN_W-1:0]  col_r;
  logic [fwm_pkg::LEN_W-1:0]  prev_r;
  logic [fwm_pkg::LEN_W-1:0]  col_nxt;
  logic [fwm_pkg::LEN_W-1:0]  sub_cost;
  logic [fwm_pkg::LEN_W-1:0]  up_cost;
  logic [fwm_pkg::LEN_W-1:0]  left_cost;

  // Three-way minimum of substitute, delete and insert
  always_comb begin
    sub_cost  = wave_in.diag + ((wave_in.ch != ref_char) ? fwm_pkg::LEN_W'(1)
                                                         : fwm_pkg::LEN_W'(0));
    up_cost   = col_r + fwm_pkg::LEN_W'(1);
    left_cost = wave_in.left + fwm_pkg::LEN_W'(1);
    col_nxt   = sub_cost;
    if (up_cost < col_nxt) col_nxt = up_cost;
    if (left_cost < col_nxt) col_nxt = left_cost;
  end

  // Valid flag of the wave
  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= wave_in.vld;
    end
  end

  // Column value: row zero on init, next row on each valid wave
  always_ff @(posedge clk) begin
    if (init) begin
      col_r <= init_val;
    end else if (wave_in.vld) begin
      ch_r   <= wave_in.ch;
      prev_r <= col_r;
      col_r  <= col_nxt;
    end
  end

  assign wave_out.vld  = vld_r;
  assign wave_out.ch   = ch_r;
  assign wave_out.left = col_r;
  assign wave_out.diag = prev_r;

endmodule
`default_nettype wire

// ===== sv/fuzzy_word_match.sv =====
// Top level of the fuzzy word match block: word storage, sequencer and cell row.
// Usage:
//   Requests enter on start/busy: a request is taken at a rising edge with
//   start high and busy low. Each request carries one character for the first
//   or second word (in_word_select), or none (in_has_char low). Up to 23
//   characters per word are kept; later ones are dropped.
//   A request with in_end_of_pair high closes the pair. The block then runs
//   a row of 23 cells, one per second-word character; first-word characters
//   enter the row one per cycle and move one cell per cycle. The sequencer
//   runs until the first word has swept the row up to the second word's length and then
//   registers the result; out_valid is high with out_is_match, out_is_exact
//   and out_distance in the cycle after the last run cycle. busy is high from
//   the closing request until the result is registered. A character request
//   leaves busy low; a closing request holds busy high while the sequencer runs.
//   The receiver has no stall input: each result is shown for exactly one
//   cycle. Configuration writes use cfg_valid/cfg_ready (always ready), with
//   cfg_index 0..3 selecting the register; other indexes are ignored.
//   Synchronous reset clears both word lengths, the digit flags, the
//   sequencer and restores the register defaults (4, 8, 1, 2).
`default_nettype none
module fuzzy_word_match (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_word_select,
  input  wire logic [fwm_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic                          in_has_char,
  input  wire logic                          in_end_of_pair,
  output logic                               out_valid,
  output logic                               out_is_match,
  output logic                               out_is_exact,
  output logic [fwm_pkg::DIST_W-1:0]         out_distance,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fwm_pkg::CFG_W-1:0]     cfg_data
);

  // Configuration registers
  logic [fwm_pkg::CFG_W-1:0] short_lim_r;
  logic [fwm_pkg::CFG_W-1:0] long_lim_r;
  logic [fwm_pkg::CFG_W-1:0] near_tol_r;
  logic [fwm_pkg::CFG_W-1:0] far_tol_r;

  // Word storage and per-word status
  logic [fwm_pkg::CHAR_W-1:0] first_r  [fwm_pkg::WORD_MAX];
  logic [fwm_pkg::CHAR_W-1:0] second_r [fwm_pkg::WORD_MAX];
  logic [fwm_pkg::LEN_W-1:0]  len1_r, len1_nxt;
  logic [fwm_pkg::LEN_W-1:0]  len2_r, len2_nxt;
  logic                       dig1_r, dig1_nxt;
  logic                       dig2_r, dig2_nxt;
  logic                       last1_s_r;
  logic                       last2_s_r;

  // Sequencer
  fwm_pkg::fwm_state_t        state_r, state_nxt;
  logic [fwm_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [fwm_pkg::CNT_W-1:0]  run_len;
  logic                       accept;
  logic                       close_pair;
  logic                       done;
  logic                       store1;
  logic                       store2;
  logic                       is_digit;

  // Cell row
  fwm_pkg::wave_t             chain [fwm_pkg::WORD_MAX+1];
  fwm_pkg::wave_t             feed;

  // Decision
  logic [fwm_pkg::LEN_W-1:0]  shorter;
  logic [fwm_pkg::LEN_W-1:0]  dval;
  logic [fwm_pkg::WORD_MAX-1:0] eq_vec;
  logic                       prefix_eq;
  logic                       exact;
  logic                       plural;
  logic                       match;
  logic [fwm_pkg::CFG_W-1:0]  tol;

  // Output registers
  logic                       out_valid_r;
  logic                       out_match_r;
  logic                       out_exact_r;
  logic [fwm_pkg::DIST_W-1:0] out_dist_r;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_lim_r <= fwm_pkg::SHORT_LIMIT_RST;
      long_lim_r  <= fwm_pkg::LONG_LIMIT_RST;
      near_tol_r  <= fwm_pkg::NEAR_TOL_RST;
      far_tol_r   <= fwm_pkg::FAR_TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fwm_pkg::CFG_SHORT_LIMIT: short_lim_r <= cfg_data;
        fwm_pkg::CFG_LONG_LIMIT:  long_lim_r  <= cfg_data;
        fwm_pkg::CFG_NEAR_TOL:    near_tol_r  <= cfg_data;
        fwm_pkg::CFG_FAR_TOL:     far_tol_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request decode
  always_comb begin
    accept     = start && !busy;
    close_pair = accept && in_end_of_pair;
    store1     = accept && in_has_char && !in_word_select &&
                 (len1_r < fwm_pkg::LEN_W'(fwm_pkg::WORD_MAX));
    store2     = accept && in_has_char && in_word_select &&
                 (len2_r < fwm_pkg::LEN_W'(fwm_pkg::WORD_MAX));
    is_digit   = in_char_code inside {[fwm_pkg::CHAR_ZERO:fwm_pkg::CHAR_NINE]};
  end

  // Length and digit flag update; cleared once the result is registered
  always_comb begin
    len1_nxt = len1_r;
    len2_nxt = len2_r;
    dig1_nxt = dig1_r;
    dig2_nxt = dig2_r;
    if (done) begin
      len1_nxt = '0;
      len2_nxt = '0;
      dig1_nxt = 1'b0;
      dig2_nxt = 1'b0;
    end else begin
      if (store1) begin
        len1_nxt = len1_r + fwm_pkg::LEN_W'(1);
        dig1_nxt = dig1_r || is_digit;
      end
      if (store2) begin
        len2_nxt = len2_r + fwm_pkg::LEN_W'(1);
        dig2_nxt = dig2_r || is_digit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len1_r <= '0;
      len2_r <= '0;
      dig1_r <= 1'b0;
      dig2_r <= 1'b0;
    end else begin
      len1_r <= len1_nxt;
      len2_r <= len2_nxt;
      dig1_r <= dig1_nxt;
      dig2_r <= dig2_nxt;
    end
  end

  // Character store, one address per word
  always_ff @(posedge clk) begin
    if (store1) begin
      first_r[len1_r[fwm_pkg::IDX_W-1:0]] <= in_char_code;
      last1_s_r <= (in_char_code == fwm_pkg::CHAR_S);
    end
    if (store2) begin
      second_r[len2_r[fwm_pkg::IDX_W-1:0]] <= in_char_code;
      last2_s_r <= (in_char_code == fwm_pkg::CHAR_S);
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fwm_pkg::ST_IDLE: if (close_pair) state_nxt = fwm_pkg::ST_RUN;
      fwm_pkg::ST_RUN:  if (done) state_nxt = fwm_pkg::ST_IDLE;
      default:          state_nxt = fwm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    run_len = fwm_pkg::CNT_W'(len1_r) + fwm_pkg::CNT_W'(len2_r);
    busy    = 1'b0;
    done    = 1'b0;
    cnt_nxt = cnt_r;
    case (state_r)
      fwm_pkg::ST_IDLE: begin
        cnt_nxt = '0;
      end
      fwm_pkg::ST_RUN: begin
        busy    = 1'b1;
        done    = (cnt_r == run_len);
        cnt_nxt = cnt_r + fwm_pkg::CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fwm_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Row feed: one first-word character per cycle with its boundary column
  always_comb begin
    feed.vld  = (state_r == fwm_pkg::ST_RUN) && (cnt_r < fwm_pkg::CNT_W'(len1_r));
    feed.ch   = first_r[cnt_r[fwm_pkg::IDX_W-1:0]];
    feed.left = fwm_pkg::LEN_W'(cnt_r) + fwm_pkg::LEN_W'(1);
    feed.diag = fwm_pkg::LEN_W'(cnt_r);
  end

  assign chain[0] = feed;

  // Cell row, one cell per second-word position
  for (genvar k = 0; k < fwm_pkg::WORD_MAX; k++) begin : g_cell
    fwm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .init     (close_pair),
      .init_val (fwm_pkg::LEN_W'(k + 1)),
      .ref_char (second_r[k]),
      .wave_in  (chain[k]),
      .wave_out (chain[k+1])
    );
  end

  // Distance pick-off at the column of the second word's length
  always_comb begin
    dval = len1_r;
    for (int k = 0; k < fwm_pkg::WORD_MAX; k++) begin
      if (len2_r == fwm_pkg::LEN_W'(k + 1)) dval = chain[k+1].left;
    end
  end

  // Position-wise compare over the shorter word
  always_comb begin
    shorter = (len1_r < len2_r) ? len1_r : len2_r;
    for (int k = 0; k < fwm_pkg::WORD_MAX; k++) begin
      eq_vec[k] = (first_r[k] == second_r[k]) ||
                  (fwm_pkg::LEN_W'(k) >= shorter);
    end
    prefix_eq = &eq_vec;
    exact     = (len1_r == len2_r) && prefix_eq;
    plural    = prefix_eq &&
                (((len1_r == len2_r + fwm_pkg::LEN_W'(1)) && last1_s_r) ||
                 ((len2_r == len1_r + fwm_pkg::LEN_W'(1)) && last2_s_r));
    tol       = (fwm_pkg::CMP_W'(shorter) >= fwm_pkg::CMP_W'(long_lim_r)) ?
                far_tol_r : near_tol_r;
    if (exact) begin
      match = 1'b1;
    end else if (dig1_r || dig2_r) begin
      match = 1'b0;
    end else if (fwm_pkg::CMP_W'(shorter) <= fwm_pkg::CMP_W'(short_lim_r)) begin
      match = plural;
    end else begin
      match = (fwm_pkg::CMP_W'(dval) <= fwm_pkg::CMP_W'(tol));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_match_r <= match;
      out_exact_r <= exact;
      out_dist_r  <= (32'(dval) > fwm_pkg::DIST_SAT) ? fwm_pkg::DIST_W'(fwm_pkg::DIST_SAT)
                                                    : fwm_pkg::DIST_W'(dval);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_match = out_match_r;
  assign out_is_exact = out_exact_r;
  assign out_distance = out_dist_r;

endmodule
`default_nettype wire

// ===== bench/tb_fuzzy_word_match.sv =====
// Self-checking testbench for the fuzzy word match block: directed pairs, register sweep, random traffic.
module tb_fuzzy_word_match;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int DRAIN_CYCLES  = 2 * fwm_pkg::WORD_STORE + 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int ITEM_TARGET   = 1350;
  localparam int MAX_SHOWN     = 10;
  localparam int SWEEP_PAIRS   = 8;
  localparam int PHASE_PAIRS   = 20;
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_HEAVY    = 72;
  localparam int IDLE_LIGHT    = 22;
  localparam logic SEL_FIRST   = 1'b0;
  localparam logic SEL_SECOND  = 1'b1;
  localparam logic [fwm_pkg::CHAR_W-1:0] CHAR_A = 8'h61;

  typedef struct packed {
    logic                       is_match;
    logic                       is_exact;
    logic [fwm_pkg::DIST_W-1:0] distance;
  } match_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic                          in_word_select;
  logic [fwm_pkg::CHAR_W-1:0]    in_char_code;
  logic                          in_has_char;
  logic                          in_end_of_pair;
  logic                          out_valid;
  logic                          out_is_match;
  logic                          out_is_exact;
  logic [fwm_pkg::DIST_W-1:0]    out_distance;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [fwm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fwm_pkg::CFG_W-1:0]     cfg_data;

  // Predictor state: stored words, lengths, digit flags, registers
  logic [fwm_pkg::CHAR_W-1:0] first_chars [fwm_pkg::WORD_MAX];
  logic [fwm_pkg::CHAR_W-1:0] second_chars[fwm_pkg::WORD_MAX];
  int                         first_len;
  int                         second_len;
  bit                         first_digit;
  bit                         second_digit;
  logic [fwm_pkg::CFG_W-1:0]  short_limit;
  logic [fwm_pkg::CFG_W-1:0]  long_limit;
  logic [fwm_pkg::CFG_W-1:0]  near_tol;
  logic [fwm_pkg::CFG_W-1:0]  far_tol;

  match_result_t pending_results[$];
  int            idle_pct;
  int            items_sent;
  int            results_seen;
  int            settings_applied;
  int            fail_count;
  int            cycle_count;

  fuzzy_word_match u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_word_select(in_word_select),
    .in_char_code  (in_char_code),
    .in_has_char   (in_has_char),
    .in_end_of_pair(in_end_of_pair),
    .out_valid     (out_valid),
    .out_is_match  (out_is_match),
    .out_is_exact  (out_is_exact),
    .out_distance  (out_distance),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Row-by-row edit distance of the stored words
  function automatic int pair_distance();
    int row[fwm_pkg::WORD_STORE + 1];
    int i, j, diag, above, best;
    for (j = 0; j <= second_len; j++) row[j] = j;
    for (i = 1; i <= first_len; i++) begin
      diag   = row[0];
      row[0] = i;
      for (j = 1; j <= second_len; j++) begin
        above = row[j];
        best  = diag + ((first_chars[i-1] != second_chars[j-1]) ? 1 : 0);
        if (above + 1 < best) best = above + 1;
        if (row[j-1] + 1 < best) best = row[j-1] + 1;
        row[j] = best;
        diag   = above;
      end
    end
    return row[second_len];
  endfunction

  // True when one word is the other plus a trailing 's'
  function automatic bit plural_pair(bit first_longer);
    int llen, slen, k;
    logic [fwm_pkg::CHAR_W-1:0] tail;
    llen = first_longer ? first_len : second_len;
    slen = first_longer ? second_len : first_len;
    if (llen != slen + 1 || llen == 0) return 1'b0;
    tail = first_longer ? first_chars[llen-1] : second_chars[llen-1];
    if (tail != fwm_pkg::CHAR_S) return 1'b0;
    for (k = 0; k < slen; k++)
      if (first_chars[k] != second_chars[k]) return 1'b0;
    return 1'b1;
  endfunction

  // Update the predictor with one accepted request
  task automatic predict_request(input logic sel, input logic [fwm_pkg::CHAR_W-1:0] ch,
                                 input logic has, input logic eop);
    match_result_t res;
    int lev, shorter, k;
    bit exact, digit;
    logic [fwm_pkg::CFG_W-1:0] tol;
    digit = (ch >= fwm_pkg::CHAR_ZERO) && (ch <= fwm_pkg::CHAR_NINE);
    if (has) begin
      if (sel == SEL_FIRST) begin
        if (first_len < fwm_pkg::WORD_MAX) begin
          first_chars[first_len] = ch;
          first_len++;
          if (digit) first_digit = 1'b1;
        end
      end else begin
        if (second_len < fwm_pkg::WORD_MAX) begin
          second_chars[second_len] = ch;
          second_len++;
          if (digit) second_digit = 1'b1;
        end
      end
    end
    if (eop) begin
      lev   = pair_distance();
      exact = (first_len == second_len);
      for (k = 0; exact && k < first_len; k++)
        if (first_chars[k] != second_chars[k]) exact = 1'b0;
      shorter = (first_len < second_len) ? first_len : second_len;
      if (exact) res.is_match = 1'b1;
      else if (first_digit || second_digit) res.is_match = 1'b0;
      else if (shorter <= short_limit) res.is_match = plural_pair(1'b1) || plural_pair(1'b0);
      else begin
        tol = (shorter >= long_limit) ? far_tol : near_tol;
        res.is_match = (lev <= tol);
      end
      res.is_exact = exact;
      res.distance = (lev > fwm_pkg::DIST_SAT) ? fwm_pkg::DIST_W'(fwm_pkg::DIST_SAT)
                                               : fwm_pkg::DIST_W'(lev);
      pending_results.push_back(res);
      first_len    = 0;
      second_len   = 0;
      first_digit  = 1'b0;
      second_digit = 1'b0;
    end
  endtask

  // Send one request, idling at random beforehand
  task automatic send_request(input logic sel, input logic [fwm_pkg::CHAR_W-1:0] ch,
                              input logic has, input logic eop);
    @(negedge clk);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_word_select <= sel;
    in_char_code   <= ch;
    in_has_char    <= has;
    in_end_of_pair <= eop;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(sel, ch, has, eop);
    items_sent++;
  endtask

  task automatic send_text(input logic sel, input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_request(sel, s[k], 1'b1, 1'b0);
  endtask

  // Stop requesting and wait for every expected result
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [fwm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fwm_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fwm_pkg::CFG_SHORT_LIMIT: short_limit = val;
      fwm_pkg::CFG_LONG_LIMIT:  long_limit  = val;
      fwm_pkg::CFG_NEAR_TOL:    near_tol    = val;
      fwm_pkg::CFG_FAR_TOL:     far_tol     = val;
      default: ;
    endcase
  endtask

  // All four registers, then a write to an unused index that must be ignored
  task automatic apply_settings(input logic [fwm_pkg::CFG_W-1:0] s,
                                input logic [fwm_pkg::CFG_W-1:0] l,
                                input logic [fwm_pkg::CFG_W-1:0] n,
                                input logic [fwm_pkg::CFG_W-1:0] f);
    logic [fwm_pkg::CFG_IDX_W-1:0] spare;
    spare = fwm_pkg::CFG_IDX_W'($urandom_range(fwm_pkg::CFG_FAR_TOL + 1,
                                               (1 << fwm_pkg::CFG_IDX_W) - 1));
    cfg_write(fwm_pkg::CFG_SHORT_LIMIT, s);
    cfg_write(fwm_pkg::CFG_LONG_LIMIT, l);
    cfg_write(fwm_pkg::CFG_NEAR_TOL, n);
    cfg_write(fwm_pkg::CFG_FAR_TOL, f);
    cfg_write(spare, fwm_pkg::CFG_W'($urandom_range(0, fwm_pkg::DIST_SAT)));
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  function automatic logic [fwm_pkg::CHAR_W-1:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 84) return fwm_pkg::CHAR_W'(CHAR_A + $urandom_range(0, 25));
    else if (r < 92) return fwm_pkg::CHAR_S;
    else if (r < 96) return fwm_pkg::CHAR_W'(fwm_pkg::CHAR_ZERO + $urandom_range(0, 9));
    else return fwm_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [fwm_pkg::CFG_W-1:0] random_setting();
    if ($urandom_range(0, 1)) return fwm_pkg::CFG_W'($urandom_range(0, 8));
    return fwm_pkg::CFG_W'($urandom_range(0, fwm_pkg::DIST_SAT));
  endfunction

  // One pair: a random word and a second one, mostly related, bytes interleaved with noise
  task automatic run_random_pair();
    logic [fwm_pkg::CHAR_W-1:0] wa[$], wb[$], tmp[$];
    int len, kind, pos, ia, ib, total, k;
    bit close_with_char, last;
    len = ($urandom_range(0, 99) < 8) ? $urandom_range(20, 26) : $urandom_range(0, 10);
    for (k = 0; k < len; k++) wa.push_back(random_char());
    wb   = wa;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      // identical words
    end else if (kind < 40) begin
      wb.push_back(fwm_pkg::CHAR_S);
    end else if (kind < 55) begin
      if (wb.size() > 0) wb[$urandom_range(0, wb.size() - 1)] = random_char();
    end else if (kind < 65) begin
      // insertion
      pos = $urandom_range(0, wb.size());
      tmp.delete();
      for (k = 0; k <= wb.size(); k++) begin
        if (k == pos) tmp.push_back(random_char());
        if (k < wb.size()) tmp.push_back(wb[k]);
      end
      wb = tmp;
    end else if (kind < 75) begin
      // deletion
      if (wb.size() > 0) begin
        pos = $urandom_range(0, wb.size() - 1);
        tmp.delete();
        for (k = 0; k < wb.size(); k++) if (k != pos) tmp.push_back(wb[k]);
        wb = tmp;
      end
    end else if (kind < 85) begin
      if (wb.size() > 0) begin
        wb[$urandom_range(0, wb.size() - 1)] = random_char();
        wb[$urandom_range(0, wb.size() - 1)] = random_char();
      end
    end else begin
      wb.delete();
      len = $urandom_range(0, 10);
      for (k = 0; k < len; k++) wb.push_back(random_char());
    end
    if ($urandom_range(0, 1)) begin
      tmp = wa;
      wa  = wb;
      wb  = tmp;
    end
    total           = wa.size() + wb.size();
    close_with_char = (total > 0) && $urandom_range(0, 1);
    ia = 0;
    ib = 0;
    while (ia < wa.size() || ib < wb.size()) begin
      if ($urandom_range(0, 99) < 4)
        send_request(1'($urandom_range(0, 1)), fwm_pkg::CHAR_W'($urandom_range(0, 255)),
                     1'b0, 1'b0);
      last = close_with_char && (ia + ib + 1 == total);
      if (ib >= wb.size() || (ia < wa.size() && $urandom_range(0, 1))) begin
        send_request(SEL_FIRST, wa[ia], 1'b1, last);
        ia++;
      end else begin
        send_request(SEL_SECOND, wb[ib], 1'b1, last);
        ib++;
      end
    end
    if (!close_with_char)
      send_request(1'($urandom_range(0, 1)), fwm_pkg::CHAR_W'($urandom_range(0, 255)),
                   1'b0, 1'b1);
  endtask

  // Directed pairs at reset settings
  task automatic test_directed_cases();
    idle_pct = IDLE_NONE;
    // empty words, ignored top byte
    send_request(SEL_FIRST, 8'hFF, 1'b0, 1'b1);
    // plural of a short word
    send_text(SEL_FIRST, "ox");
    send_text(SEL_SECOND, "oxs");
    send_request(SEL_SECOND, 8'h00, 1'b0, 1'b1);
    // zero bytes, the second one closes the pair
    send_request(SEL_FIRST, 8'h00, 1'b1, 1'b0);
    send_request(SEL_SECOND, 8'h00, 1'b1, 1'b1);
    // digits block a near match
    send_request(SEL_FIRST, "a", 1'b1, 1'b0);
    send_request(SEL_SECOND, "a", 1'b1, 1'b0);
    send_request(SEL_FIRST, "1", 1'b1, 1'b0);
    send_request(SEL_SECOND, "2", 1'b1, 1'b1);
    // top byte values, single-byte words
    send_request(SEL_SECOND, 8'hFF, 1'b1, 1'b0);
    send_request(SEL_FIRST, 8'hFE, 1'b1, 1'b1);
    // medium words one substitution apart
    send_text(SEL_FIRST, "abcde");
    send_text(SEL_SECOND, "abxde");
    send_request(SEL_FIRST, 8'h00, 1'b0, 1'b1);
  endtask

  // Extreme and typical register settings
  task automatic test_register_sweep();
    int s, p;
    idle_pct = IDLE_NONE;
    for (s = 0; s < 5; s++) begin
      wait_idle();
      case (s)
        0: apply_settings(5'd0, 5'd0, 5'd0, 5'd0);
        1: apply_settings(5'd23, 5'd23, 5'd23, 5'd23);
        2: apply_settings(5'd31, 5'd31, 5'd31, 5'd31);
        3: apply_settings(5'd1, 5'd23, 5'd0, 5'd31);
        default: apply_settings(fwm_pkg::SHORT_LIMIT_RST, fwm_pkg::LONG_LIMIT_RST,
                                fwm_pkg::NEAR_TOL_RST, fwm_pkg::FAR_TOL_RST);
      endcase
      for (p = 0; p < SWEEP_PAIRS; p++) run_random_pair();
    end
  endtask

  // Random pairs under random settings and idle patterns
  task automatic test_random_traffic();
    int phase, p;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      apply_settings(random_setting(), random_setting(), random_setting(), random_setting());
      case (phase % 3)
        0: idle_pct = IDLE_NONE;
        1: idle_pct = IDLE_HEAVY;
        default: idle_pct = IDLE_LIGHT;
      endcase
      for (p = 0; p < PHASE_PAIRS; p++) begin
        run_random_pair();
        if (p == PHASE_PAIRS / 2) drain_results();
      end
      phase++;
    end
  endtask

  task automatic note_failure(input string what, input match_result_t want,
                              input match_result_t got);
    fail_count++;
    if (fail_count <= MAX_SHOWN)
      $display("%s: expected match=%0b exact=%0b dist=%0d, got match=%0b exact=%0b dist=%0d",
               what, want.is_match, want.is_exact, want.distance,
               got.is_match, got.is_exact, got.distance);
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    match_result_t want, got;
    if (rst_n && out_valid) begin
      results_seen++;
      got.is_match = out_is_match;
      got.is_exact = out_is_exact;
      got.distance = out_distance;
      if (pending_results.size() == 0) begin
        want = '0;
        note_failure("unexpected result", want, got);
      end else begin
        want = pending_results.pop_front();
        if (got.is_match !== want.is_match || got.is_exact !== want.is_exact ||
            got.distance !== want.distance)
          note_failure("result mismatch", want, got);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("[fuzzy_word_match] ERROR");
      $finish;
    end
  end

  // Sequence
  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_word_select = 1'b0;
    in_char_code   = '0;
    in_has_char    = 1'b0;
    in_end_of_pair = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    short_limit    = fwm_pkg::SHORT_LIMIT_RST;
    long_limit     = fwm_pkg::LONG_LIMIT_RST;
    near_tol       = fwm_pkg::NEAR_TOL_RST;
    far_tol        = fwm_pkg::FAR_TOL_RST;
    first_len      = 0;
    second_len     = 0;
    first_digit    = 1'b0;
    second_digit   = 1'b0;
    idle_pct       = IDLE_NONE;
    items_sent     = 0;
    results_seen   = 0;
    settings_applied = 0;
    fail_count     = 0;
    cycle_count    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_register_sweep();
    test_random_traffic();
    wait_idle();

    $display("Ran %0d requests and %0d pair results over %0d register settings",
             items_sent, results_seen, settings_applied);
    $display("with sender idling at 0, 22 and 72 percent; %0d failures", fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[fuzzy_word_match] OK");
    end else begin
      $display("[fuzzy_word_match] ERROR");
    end
    $finish;
  end

endmodule
